### hw/rtl/btpp_pkg.sv
// Package for the balanced tree particle partition block.
// Field widths, register indexes and fill-count limits; no dependencies.
package btpp_pkg;

	localparam int PID_W    = 10;
	localparam int CELLO_W  = 11;
	localparam int LVL_W    = 4;
	localparam int PCNT_W   = 11;
	localparam int FILL_W   = 11;
	localparam int SH_W     = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [FILL_W-1:0] FILL_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT    = 1'd1;

	localparam int DEF_MAX_LEVELS    = 10;
	localparam int DEF_MAX_PARTICLES = 1024;
	localparam int DEF_MAX_CELLS     = 2047;

endpackage

### hw/rtl/balanced_tree_particle_partition_top.sv
// Top level of the balanced tree particle partition block; depends on btpp_pkg.
// Holds the particle-cell and cell-fill memories and the item sequencer.
// Items pass the slot, cell, fill, next-cell and result states (slot and next-cell repeat per
// index wrap); an out-of-range level skips from cell to result, a restart from idle to result.
// One item at a time through the serial read-modify-write chain; result waits on out_ready.
// Reset and each restart clear both memories over the larger depth with in_ready low.
module balanced_tree_particle_partition_top
	import btpp_pkg::*;
#(
	parameter int MAX_LEVELS    = DEF_MAX_LEVELS,
	parameter int MAX_PARTICLES = DEF_MAX_PARTICLES,
	parameter int MAX_CELLS     = DEF_MAX_CELLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PCNT_W-1:0]    cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 restart,
	input  logic [LVL_W-1:0]     level,
	input  logic [PID_W-1:0]     particle,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PID_W-1:0]     particle_out,
	output logic [CELLO_W-1:0]   new_cell,
	output logic                 bad_level
);

	localparam int SLOT_W    = $clog2(MAX_PARTICLES);
	localparam int CELL_W    = $clog2(MAX_CELLS);
	localparam int CLR_DEPTH = (MAX_PARTICLES > MAX_CELLS) ? MAX_PARTICLES : MAX_CELLS;
	localparam int CLR_W     = $clog2(CLR_DEPTH);
	localparam int NXT_W     = ((CELL_W > MAX_LEVELS + 1) ? CELL_W : MAX_LEVELS + 1) + 1;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SLOT  = 3'd2;
	localparam logic [2:0] S_CELL  = 3'd3;
	localparam logic [2:0] S_FILL  = 3'd4;
	localparam logic [2:0] S_NEXT  = 3'd5;
	localparam logic [2:0] S_RES   = 3'd6;

	logic [2:0]         state_q;
	logic [CLR_W-1:0]   clr_q;
	logic [PCNT_W-1:0]  pcnt_q;
	logic [LVL_W-1:0]   lcnt_q;

	logic [PID_W-1:0]   pid_q;
	logic [PID_W-1:0]   slot_q;
	logic [LVL_W-1:0]   level_q;
	logic               restart_q;
	logic               bad_q;
	logic [CELL_W-1:0]  cell_q;
	logic [NXT_W-1:0]   next_q;
	logic [CELLO_W-1:0] res_cell_q;
	logic               res_bad_q;

	logic               out_valid_q;
	logic [PID_W-1:0]   out_pid_q;
	logic [CELLO_W-1:0] out_cell_q;
	logic               out_bad_q;

	logic [CELL_W-1:0]  pc_mem [MAX_PARTICLES];
	logic [FILL_W-1:0]  cf_mem [MAX_CELLS];
	logic [CELL_W-1:0]  pc_rdata;
	logic [FILL_W-1:0]  cf_rdata;

	logic               pc_we;
	logic [SLOT_W-1:0]  pc_waddr;
	logic [CELL_W-1:0]  pc_wdata;
	logic               pc_re;
	logic [SLOT_W-1:0]  pc_raddr;
	logic               cf_we;
	logic [CELL_W-1:0]  cf_waddr;
	logic [FILL_W-1:0]  cf_wdata;
	logic               cf_re;

	logic [SH_W-1:0]    eff_lvl;
	logic [SH_W-1:0]    shift_amt;
	logic [FILL_W-1:0]  fill_new;
	logic [PCNT_W-1:0]  fill_lim;
	logic               first_child;
	logic               accept;
	logic               res_load;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign res_load = (state_q == S_RES) && (!out_valid_q || out_ready);

	assign eff_lvl     = (lcnt_q < MAX_LEVELS) ? SH_W'(lcnt_q) : SH_W'(MAX_LEVELS);
	assign shift_amt   = eff_lvl - SH_W'(level_q);
	assign fill_new    = (cf_rdata == FILL_MAX) ? cf_rdata : cf_rdata + FILL_W'(1);
	assign fill_lim    = pcnt_q >> (SH_W'(level_q) + SH_W'(1));
	assign first_child = (PCNT_W'(fill_new) <= fill_lim);

	always_comb begin
		pc_we    = 1'b0;
		pc_waddr = SLOT_W'(slot_q);
		pc_wdata = CELL_W'(next_q);
		pc_re    = 1'b0;
		pc_raddr = SLOT_W'(slot_q);
		cf_we    = 1'b0;
		cf_waddr = cell_q;
		cf_wdata = fill_new;
		cf_re    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				pc_we    = (clr_q < MAX_PARTICLES);
				pc_waddr = SLOT_W'(clr_q);
				pc_wdata = '0;
				cf_we    = (clr_q < MAX_CELLS);
				cf_waddr = CELL_W'(clr_q);
				cf_wdata = '0;
			end
			S_SLOT: begin
				pc_re = (slot_q < MAX_PARTICLES);
			end
			S_CELL: begin
				cf_re = !bad_q;
			end
			S_FILL: begin
				cf_we = 1'b1;
			end
			S_NEXT: begin
				pc_we = (next_q < MAX_CELLS);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pc_we) begin
			pc_mem[pc_waddr] <= pc_wdata;
		end
		if (pc_re) begin
			pc_rdata <= pc_mem[pc_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cf_we) begin
			cf_mem[cf_waddr] <= cf_wdata;
		end
		if (cf_re) begin
			cf_rdata <= cf_mem[pc_rdata];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= PCNT_W'(1);
			lcnt_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PARTICLE_COUNT: pcnt_q <= cfg_wdata;
				REG_LEVEL_COUNT:    lcnt_q <= cfg_wdata[LVL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + CLR_W'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= restart ? S_RES : S_SLOT;
					end
				end
				S_SLOT: begin
					if (slot_q < MAX_PARTICLES) begin
						state_q <= S_CELL;
					end
				end
				S_CELL: begin
					state_q <= bad_q ? S_RES : S_FILL;
				end
				S_FILL: begin
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (next_q < MAX_CELLS) begin
						state_q <= S_RES;
					end
				end
				S_RES: begin
					if (res_load) begin
						state_q <= restart_q ? S_CLEAR : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					pid_q      <= particle;
					slot_q     <= particle;
					level_q    <= level;
					restart_q  <= restart;
					bad_q      <= (SH_W'(level) >= eff_lvl);
					res_cell_q <= '0;
					res_bad_q  <= 1'b0;
				end
			end
			S_SLOT: begin
				if (!(slot_q < MAX_PARTICLES)) begin
					slot_q <= slot_q - PID_W'(MAX_PARTICLES);
				end
			end
			S_CELL: begin
				cell_q     <= pc_rdata;
				res_cell_q <= CELLO_W'(pc_rdata);
				res_bad_q  <= bad_q;
			end
			S_FILL: begin
				if (first_child) begin
					next_q <= NXT_W'(cell_q) + NXT_W'(1);
				end else begin
					next_q <= NXT_W'(cell_q) + (NXT_W'(1) << shift_amt);
				end
			end
			S_NEXT: begin
				if (next_q < MAX_CELLS) begin
					res_cell_q <= CELLO_W'(next_q);
				end else begin
					next_q <= next_q - NXT_W'(MAX_CELLS);
				end
			end
			default: begin
			end
		endcase
		if (res_load) begin
			out_pid_q  <= pid_q;
			out_cell_q <= res_cell_q;
			out_bad_q  <= res_bad_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign particle_out = out_pid_q;
	assign new_cell     = out_cell_q;
	assign bad_level    = out_bad_q;

`ifndef SYNTHESIS
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("input taken during clearing pass");

	a_bad_level_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CELL && bad_q) |-> (!pc_we && !cf_we && !cf_re))
		else $error("out-of-range level touched the stores");

	a_fill_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		cf_we |-> (state_q == S_FILL || state_q == S_CLEAR))
		else $error("fill write outside update or clear");

	a_cell_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_we && state_q == S_NEXT) |-> (next_q < MAX_CELLS))
		else $error("cell index written before wrap");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("sequencer stayed idle after a transaction");
`endif

endmodule
